[sv/fsfx_pkg.sv]
// ----------------------------------------------------------------------------
// Frame sound-effect sequencer package
// Shared payload types, request bit positions, lookup tables and constants.
// ----------------------------------------------------------------------------
package fsfx_pkg;

    // Default depth of the note ROM address space.
    localparam int NOTE_ROM_DEPTH_DEF = 256;

    // Number of ROM locations that hold melody data.
    localparam int ROM_USED = 170;

    // Request bit positions in the pending request word.
    localparam int RQ_START  = 0;
    localparam int RQ_ALIEN  = 1;
    localparam int RQ_FLAG   = 2;
    localparam int RQ_ATTACK = 3;
    localparam int RQ_LIFE   = 4;
    localparam int RQ_COIN   = 5;
    localparam int RQ_SHOOT  = 6;
    localparam int RQ_DYING  = 7;
    localparam int RQ_SWARM  = 8;
    localparam int RQ_COUNT  = 9;

    // Melody selection codes.
    localparam logic [1:0] SEL_START = 2'd0;
    localparam logic [1:0] SEL_ALIEN = 2'd1;
    localparam logic [1:0] SEL_FLAG  = 2'd2;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    localparam logic [7:0] BASE_START = 8'd0;
    localparam logic [7:0] BASE_ALIEN = 8'd85;
    localparam logic [7:0] BASE_FLAG  = 8'd119;

    localparam logic [7:0] END_NOTE    = 8'hE0;
    localparam logic [7:0] PITCH_IDLE  = 8'hFF;
    localparam logic [7:0] SIREN_LOW   = 8'h60;
    localparam logic [7:0] DIVE_START  = 8'hA0;
    localparam logic [7:0] LIFE_START  = 8'h80;
    localparam logic [7:0] WARBLE_HIGH = 8'h80;
    localparam logic [5:0] COIN_START  = 6'h20;
    localparam logic [7:0] COIN_STEP   = 8'h04;
    localparam logic [3:0] SHOT_START  = 4'h8;
    localparam logic [4:0] BLAST_START = 5'h10;
    localparam logic [3:0] TEMPO_SLOW  = 4'hF;

    typedef struct packed {
        logic start_melody_req;
        logic alien_death_req;
        logic flagship_death_req;
        logic attack_req;
        logic extra_life_req;
        logic coin_req;
        logic shoot_req;
        logic dying_req;
        logic swarm_reset_req;
        logic in_play;
        logic game_over;
        logic no_aliens_diving;
    } fsfx_in_t;

    typedef struct packed {
        logic [7:0] pitch_value;
        logic       volume_bit_a;
        logic       volume_bit_b;
        logic       fire_noise_on;
        logic       hit_noise_on;
        logic       tempo_write;
        logic [3:0] tempo_value;
    } fsfx_out_t;

    // Packed melodies: game start, alien death, flagship death.
    localparam logic [7:0] NOTE_ROM [0:ROM_USED-1] = '{
        8'h11,8'h10,8'h0F,8'h0E,8'h0D,8'h0C,8'h0B,8'h0A,
        8'h09,8'h08,8'h07,8'h41,8'h42,8'h41,8'h42,8'h45,
        8'h42,8'h45,8'h47,8'h45,8'h47,8'h6A,8'h60,8'h41,
        8'h42,8'h41,8'h42,8'h45,8'h42,8'h45,8'h47,8'h45,
        8'h47,8'h6A,8'h60,8'h45,8'h23,8'h24,8'h23,8'h24,
        8'h23,8'h24,8'h23,8'h24,8'h23,8'h24,8'h23,8'h24,
        8'h23,8'h24,8'h23,8'h24,8'h02,8'h03,8'h05,8'h06,
        8'h07,8'h08,8'h09,8'h0A,8'h02,8'h03,8'h05,8'h06,
        8'h07,8'h08,8'h09,8'h0A,8'h02,8'h03,8'h05,8'h06,
        8'h07,8'h08,8'h09,8'h0A,8'h02,8'h03,8'h05,8'h06,
        8'h07,8'h08,8'h09,8'h0A,8'hE0,
        8'h08,8'h07,8'h06,8'h05,8'h03,8'h02,8'h08,8'h07,
        8'h06,8'h05,8'h03,8'h02,8'h02,8'h03,8'h05,8'h06,
        8'h07,8'h08,8'h09,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,
        8'h0F,8'h10,8'h0F,8'h0E,8'h0D,8'h0C,8'h0B,8'h0C,
        8'h0D,8'hE0,
        8'h02,8'h17,8'h16,8'h01,8'h16,8'h02,8'h03,8'h05,
        8'h06,8'h07,8'h18,8'h20,8'h07,8'h06,8'h05,8'h03,
        8'h02,8'h03,8'h06,8'h07,8'h08,8'h09,8'h0A,8'h19,
        8'h20,8'h0A,8'h09,8'h08,8'h07,8'h08,8'h0A,8'h0B,
        8'h0C,8'h0D,8'h0E,8'h1A,8'h20,8'h0E,8'h0D,8'h0C,
        8'h0B,8'h0A,8'h0B,8'h0D,8'h0E,8'h0F,8'h10,8'h11,
        8'h1B,8'h3C,8'hE0
    };

    localparam logic [7:0] PITCH_ROM [0:31] = '{
        8'hFF,8'h00,8'h40,8'h55,8'h5F,8'h68,8'h70,8'h80,
        8'h8E,8'h9A,8'hA0,8'hAA,8'hB4,8'hB8,8'hC0,8'hC7,
        8'hCD,8'hD0,8'hD5,8'hDA,8'hDC,8'hE0,8'h1C,8'h35,
        8'h87,8'hA5,8'hC4,8'hD3,8'hCA,8'hE3,8'hE6,8'hFF
    };

    localparam logic [7:0] LENGTH_ROM [0:7] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h00
    };

endpackage

[sv/fsfx_note_rd.sv]
// ----------------------------------------------------------------------------
// Note ROM reader
// Maps a melody selection and position to a packed note byte.
// ----------------------------------------------------------------------------
module fsfx_note_rd #(
    parameter int NOTE_ROM_DEPTH = fsfx_pkg::NOTE_ROM_DEPTH_DEF
) (
    input  logic [1:0] sel,
    input  logic [6:0] pos,
    output logic [7:0] note
);
    import fsfx_pkg::*;

    logic [7:0] base;
    logic [8:0] addr;

    always_comb
    begin
        case (sel)
            SEL_START: base = BASE_START;
            SEL_ALIEN: base = BASE_ALIEN;
            SEL_FLAG:  base = BASE_FLAG;
            default:   base = BASE_START;
        endcase
        addr = {1'b0, base} + {2'b00, pos};
        // Addresses past the packed data, and the unused selection, read as the end marker.
        if (sel == SEL_NONE || 32'(addr) >= 32'(ROM_USED)
            || 32'(addr) >= 32'(NOTE_ROM_DEPTH))
        begin
            note = END_NOTE;
        end
        else
        begin
            note = NOTE_ROM[addr[7:0]];
        end
    end

endmodule

[sv/fsfx_frame_core.sv]
// ----------------------------------------------------------------------------
// Frame core
// Holds the sequencer state and runs the per-frame priority chain.
// ----------------------------------------------------------------------------
module fsfx_frame_core #(
    parameter int NOTE_ROM_DEPTH = fsfx_pkg::NOTE_ROM_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  fsfx_pkg::fsfx_in_t  frame,
    output fsfx_pkg::fsfx_out_t res
);
    import fsfx_pkg::*;

    logic [RQ_COUNT-1:0] pend_reg, pend_next;
    logic [7:0] frame_cnt_reg, frame_cnt_next;
    logic [1:0] msel_reg, msel_next;
    logic [6:0] mpos_reg, mpos_next;
    logic       mact_reg, mact_next;
    logic [7:0] ndel_reg, ndel_next;
    logic [7:0] npitch_reg, npitch_next;
    logic [5:0] ccount_reg, ccount_next;
    logic [7:0] cpitch_reg, cpitch_next;
    logic [7:0] lcount_reg, lcount_next;
    logic [1:0] sph_reg, sph_next;
    logic [7:0] dpitch_reg, dpitch_next;
    logic [3:0] scount_reg, scount_next;
    logic [4:0] bcount_reg, bcount_next;
    logic       fire_reg, fire_next;
    logic       hit_reg, hit_next;
    logic [3:0] tempo_reg, tempo_next;

    logic [RQ_COUNT-1:0] pend_in;
    logic       alien_go;
    logic       flag_go;
    logic [1:0] sel_mid;
    logic [6:0] pos_mid;
    logic [7:0] note;

    // Requests merged with this frame's triggers.
    assign pend_in = pend_reg | {frame.swarm_reset_req, frame.dying_req, frame.shoot_req,
                                 frame.coin_req, frame.extra_life_req, frame.attack_req,
                                 frame.flagship_death_req, frame.alien_death_req,
                                 frame.start_melody_req};

    assign alien_go = frame.in_play & pend_in[RQ_ALIEN];
    assign flag_go  = frame.in_play & pend_in[RQ_FLAG];

    // Melody pointer after any melody start in this frame.
    always_comb
    begin
        if (flag_go)
        begin
            sel_mid = SEL_FLAG;
        end
        else if (alien_go)
        begin
            sel_mid = SEL_ALIEN;
        end
        else if (pend_in[RQ_START])
        begin
            sel_mid = SEL_START;
        end
        else
        begin
            sel_mid = msel_reg;
        end
        pos_mid = (flag_go || alien_go || pend_in[RQ_START]) ? 7'd0 : mpos_reg;
    end

    fsfx_note_rd #(
        .NOTE_ROM_DEPTH (NOTE_ROM_DEPTH)
    ) u_note_rd (
        .sel  (sel_mid),
        .pos  (pos_mid),
        .note (note)
    );

    always_comb
    begin
        logic [7:0] pitch;
        logic       va;
        logic       vb;
        logic       tw;
        logic [8:0] mid_sum;

        pend_next      = pend_in;
        frame_cnt_next = frame_cnt_reg + 8'd1;
        msel_next      = sel_mid;
        mpos_next      = pos_mid;
        mact_next      = mact_reg;
        ndel_next      = ndel_reg;
        npitch_next    = npitch_reg;
        ccount_next    = ccount_reg;
        cpitch_next    = cpitch_reg;
        lcount_next    = lcount_reg;
        sph_next       = sph_reg;
        dpitch_next    = dpitch_reg;
        scount_next    = scount_reg;
        bcount_next    = bcount_reg;
        fire_next      = fire_reg;
        hit_next       = hit_reg;
        tempo_next     = tempo_reg;
        pitch          = PITCH_IDLE;
        va             = 1'b0;
        vb             = 1'b0;
        tw             = 1'b0;
        mid_sum        = '0;

        if (pend_in[RQ_START])
        begin
            pend_next[RQ_START] = 1'b0;
            mact_next = 1'b1;
            ndel_next = 8'd1;
        end

        if (frame.in_play)
        begin
            if (pend_in[RQ_ATTACK])
            begin
                pend_next[RQ_ATTACK] = 1'b0;
                sph_next    = 2'd2;
                dpitch_next = DIVE_START;
            end
            else if (!frame.no_aliens_diving)
            begin
                // The siren advances on even frames only.
                if (!frame_cnt_reg[0])
                begin
                    if (dpitch_reg < SIREN_LOW)
                    begin
                        sph_next = sph_reg + 2'd1;
                    end
                    if (dpitch_reg != 8'd0)
                    begin
                        dpitch_next = dpitch_reg - 8'd1;
                    end
                end
                mid_sum = {1'b0, SIREN_LOW} + {1'b0, dpitch_next};
                if (sph_next == 2'd0)
                begin
                    pitch = SIREN_LOW;
                end
                else if (!sph_next[1])
                begin
                    pitch = mid_sum[8:1];
                end
                else
                begin
                    pitch = dpitch_next;
                end
            end
            if (alien_go)
            begin
                pend_next[RQ_ALIEN] = 1'b0;
                mact_next = 1'b1;
                ndel_next = 8'd1;
            end
            if (flag_go)
            begin
                pend_next[RQ_FLAG] = 1'b0;
                mact_next = 1'b1;
                ndel_next = 8'd1;
            end
        end

        if (mact_next)
        begin
            va    = 1'b0;
            vb    = 1'b1;
            pitch = npitch_reg;
            if (ndel_next > 8'd1)
            begin
                ndel_next = ndel_next - 8'd1;
            end
            else if (note == END_NOTE)
            begin
                ndel_next = 8'd0;
                mact_next = 1'b0;
            end
            else
            begin
                ndel_next   = LENGTH_ROM[note[7:5]];
                npitch_next = PITCH_ROM[note[4:0]];
                mpos_next   = pos_mid + 7'd1;
                pitch       = npitch_next;
            end
        end

        if (pend_in[RQ_LIFE])
        begin
            pend_next[RQ_LIFE] = 1'b0;
            lcount_next = LIFE_START;
        end
        else if (lcount_reg != 8'd0)
        begin
            va = 1'b1;
            vb = 1'b0;
            lcount_next = lcount_reg - 8'd1;
            pitch = lcount_next[2] ? WARBLE_HIGH : PITCH_IDLE;
        end

        if (pend_in[RQ_COIN])
        begin
            pend_next[RQ_COIN] = 1'b0;
            ccount_next = COIN_START;
            cpitch_next = 8'd0;
            va = 1'b0;
            vb = 1'b0;
        end
        else if (ccount_reg != 6'd0)
        begin
            ccount_next = ccount_reg - 6'd1;
            cpitch_next = cpitch_reg + COIN_STEP;
            pitch = cpitch_next;
        end

        // Game over freezes both noise countdowns and their latches.
        if (!frame.game_over)
        begin
            if (pend_in[RQ_SHOOT])
            begin
                pend_next[RQ_SHOOT] = 1'b0;
                scount_next = SHOT_START;
            end
            else if (scount_reg == 4'd0)
            begin
                fire_next = 1'b0;
            end
            else
            begin
                scount_next = scount_reg - 4'd1;
                fire_next = 1'b1;
            end
            if (pend_in[RQ_DYING])
            begin
                pend_next[RQ_DYING] = 1'b0;
                bcount_next = BLAST_START;
            end
            else if (bcount_reg == 5'd0)
            begin
                hit_next = 1'b0;
            end
            else
            begin
                bcount_next = bcount_reg - 5'd1;
                hit_next = 1'b1;
            end
        end

        if (pend_in[RQ_SWARM])
        begin
            pend_next[RQ_SWARM] = 1'b0;
            tempo_next = TEMPO_SLOW;
        end
        else if (frame_cnt_reg == 8'd0 && tempo_reg != 4'd0)
        begin
            tempo_next = tempo_reg - 4'd1;
            tw = 1'b1;
        end

        res.pitch_value   = pitch;
        res.volume_bit_a  = va;
        res.volume_bit_b  = vb;
        res.fire_noise_on = fire_next;
        res.hit_noise_on  = hit_next;
        res.tempo_write   = tw;
        res.tempo_value   = tempo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= RQ_COUNT'(1) << RQ_SWARM;
            frame_cnt_reg <= '0;
            msel_reg      <= '0;
            mpos_reg      <= '0;
            mact_reg      <= 1'b0;
            ndel_reg      <= '0;
            npitch_reg    <= '0;
            ccount_reg    <= '0;
            cpitch_reg    <= '0;
            lcount_reg    <= '0;
            sph_reg       <= '0;
            dpitch_reg    <= '0;
            scount_reg    <= '0;
            bcount_reg    <= '0;
            fire_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            tempo_reg     <= '0;
        end
        else if (step)
        begin
            pend_reg      <= pend_next;
            frame_cnt_reg <= frame_cnt_next;
            msel_reg      <= msel_next;
            mpos_reg      <= mpos_next;
            mact_reg      <= mact_next;
            ndel_reg      <= ndel_next;
            npitch_reg    <= npitch_next;
            ccount_reg    <= ccount_next;
            cpitch_reg    <= cpitch_next;
            lcount_reg    <= lcount_next;
            sph_reg       <= sph_next;
            dpitch_reg    <= dpitch_next;
            scount_reg    <= scount_next;
            bcount_reg    <= bcount_next;
            fire_reg      <= fire_next;
            hit_reg       <= hit_next;
            tempo_reg     <= tempo_next;
        end
    end

endmodule

[sv/frame_sound_effect_sequencer_top.sv]
// ----------------------------------------------------------------------------
// Frame sound-effect sequencer, top level
// Per-frame sound effect control with a registered command and result stage.
// ----------------------------------------------------------------------------
// One command transaction stands for one 60 Hz frame tick: its trigger bits
// become pending requests, and one result transaction comes back with the
// tone pitch, the two volume bits, the shot and explosion noise latches and
// the swarm tempo. The block takes one command transaction per clock cycle
// when the result side keeps up; an accepted command waits in the command
// register, and its result in the result register. The sequencer state,
// including the note pointer into the melody ROM, is updated in the same
// cycle as the result register is loaded, so a command that follows
// directly behind sees the effects of the one before it. A stalled result
// only holds back new commands once the command register is also occupied.
// ----------------------------------------------------------------------------
module frame_sound_effect_sequencer_top #(
    parameter int NOTE_ROM_DEPTH = fsfx_pkg::NOTE_ROM_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  fsfx_pkg::fsfx_in_t  cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fsfx_pkg::fsfx_out_t rsp
);
    import fsfx_pkg::*;

    // Command register.
    logic     cmd_valid_reg;
    fsfx_in_t cmd_reg;

    // Result register.
    logic      rsp_valid_reg;
    fsfx_out_t rsp_reg;
    fsfx_out_t core_res;

    logic rsp_free;
    logic advance;
    logic cmd_take;

    // The result register can be loaded when empty or when its transaction leaves now.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    // The held command is processed, and the state stepped, when its result can be stored.
    assign advance  = cmd_valid_reg && rsp_free;
    // The command register takes a new transaction when empty or draining this cycle.
    assign cmd_stall = cmd_valid_reg && !rsp_free;
    assign cmd_take  = cmd_valid && !cmd_stall;

    fsfx_frame_core #(
        .NOTE_ROM_DEPTH (NOTE_ROM_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .frame (cmd_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= core_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
